[rtl/core/record_snapshot_stream_validator_assert.svh]
// assertion macros for the snapshot stream validator
// no dependencies; included by modules that carry concurrent assertions
`ifndef RECORD_SNAPSHOT_STREAM_VALIDATOR_ASSERT_SVH
`define RECORD_SNAPSHOT_STREAM_VALIDATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property holds at every clock edge out of reset
`define RSSV_ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rssv assertion failed");
// consequent holds in the cycle after the antecedent
`define RSSV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rssv sequencing assertion failed");
`else
`define RSSV_ASSERT_ALWAYS(lbl, clk, rst, prop)
`define RSSV_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/core/rssv_pkg.sv]
// shared types and constants of the snapshot stream validator
// parse phases, register indexes, verdict codes, beat layout
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rssv_pkg;

   localparam int DEF_OFFSET_BITS = 32;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_LENGTH     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_MAGIC   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_VERSION = 2'd2;

   localparam logic [31:0] RST_FRAME_LENGTH     = 32'd1;
   localparam logic [63:0] RST_EXPECTED_MAGIC   = 64'd5641112856461789522;
   localparam logic [31:0] RST_EXPECTED_VERSION = 32'd1;

   localparam logic [1:0] VERDICT_PENDING  = 2'd0;
   localparam logic [1:0] VERDICT_ACCEPTED = 2'd1;
   localparam logic [1:0] VERDICT_REJECTED = 2'd2;

   typedef enum logic [4:0] {
      PH_MAGIC    = 5'd0,
      PH_VERSION  = 5'd1,
      PH_COUNT    = 5'd2,
      PH_ROLE     = 5'd3,
      PH_PCOUNT   = 5'd4,
      PH_PTYPE    = 5'd5,
      PH_DLEN     = 5'd6,
      PH_DBYTE    = 5'd7,
      PH_NFLAG    = 5'd8,
      PH_NLEN     = 5'd9,
      PH_NBYTE    = 5'd10,
      PH_IFLAG    = 5'd11,
      PH_ILEN     = 5'd12,
      PH_IBYTE    = 5'd13,
      PH_ERRMARK  = 5'd14,
      PH_UFLAG    = 5'd15,
      PH_TOK0     = 5'd16,
      PH_TOK1     = 5'd17,
      PH_TOK2     = 5'd18,
      PH_TRAIL    = 5'd19,
      PH_AFTERERR = 5'd20
   } phase_type;

   // result beat payload, lowest field in the lowest bits
   typedef struct packed {
      logic [5:0]  pad;
      logic [1:0]  verdict;
      logic [31:0] part_index;
      logic [30:0] message_index;
      logic [63:0] field_value;
      logic        field_done;
      logic [7:0]  byte_echo;
   } rsp_data_type;

   typedef struct packed {
      logic [4:0]   field_kind;
      logic         frame_end;
      rsp_data_type data;
   } result_type;

   // bytes in each fixed-width field, zero for string byte phases
   function automatic logic [3:0] field_width(input phase_type ph);
      logic [3:0] w;
      unique case (ph)
         PH_MAGIC, PH_TOK0, PH_TOK1, PH_TOK2:              w = 4'd8;
         PH_VERSION, PH_COUNT, PH_PCOUNT,
         PH_DLEN, PH_NLEN, PH_ILEN:                        w = 4'd4;
         PH_ROLE, PH_PTYPE, PH_NFLAG, PH_IFLAG,
         PH_ERRMARK, PH_UFLAG:                             w = 4'd1;
         default:                                          w = 4'd0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

[rtl/core/record_snapshot_stream_validator.sv]
// snapshot stream validator top level: byte parser, state and result skid buffer
// depends on rssv_pkg and record_snapshot_stream_validator_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "record_snapshot_stream_validator_assert.svh"

// Checks a snapshot buffer streamed in one byte per req beat and gives one
// rsp beat per byte: the byte's field label (tuser), the byte itself, the
// finished little-endian value of a fixed-width field, the message and part
// indexes, and a verdict that is final on the beat with tlast set, which is
// the byte at offset frame_length-1. The header is an 8-byte magic, a 4-byte
// version and a 4-byte message count no larger than frame_length/2; each
// message holds a role byte, a part count, the parts and an optional usage
// block. Bytes beyond the end of the frame change nothing. The parse step is
// a single pass from the parser registers to the result register, so a beat
// can be accepted every cycle while the skid entry is empty. A two-entry
// output buffer keeps req_tready high while one finished result waits on
// rsp. The user writes registers through the csr channel only while no frame
// is in flight; the block does not check it. A new frame starts after reset.
module record_snapshot_stream_validator
   import rssv_pkg::*;
#(
   parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
   input  wire                    clock,
   input  wire                    reset,
   // config write channel
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire [CSR_INDEX_W-1:0]  csr_index,
   input  wire [63:0]             csr_wdata,
   // byte input
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire [7:0]              req_tdata,    // [7:0] data_byte
   // labelled byte output
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   // [7:0] byte_echo, [8] field_done, [72:9] field_value,
   // [103:73] message_index, [135:104] part_index, [137:136] verdict, zero pad
   output logic [143:0]           rsp_tdata,
   output logic [4:0]             rsp_tuser,    // [4:0] field_kind
   output logic                   rsp_tlast     // frame_end
);

   localparam int OFF_PAD = 33 - OFFSET_BITS;

   // config registers
   logic [31:0]            frame_length_ff;
   logic [63:0]            expected_magic_ff;
   logic [31:0]            expected_version_ff;

   // parser state
   phase_type              phase_ff, phase_in;
   logic [3:0]             bif_ff, bif_in;
   logic [63:0]            acc_ff, acc_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [30:0]            msg_total_ff, msg_total_in;
   logic [30:0]            msg_done_ff, msg_done_in;
   logic [31:0]            parts_total_ff, parts_total_in;
   logic [31:0]            parts_done_ff, parts_done_in;
   logic [31:0]            str_left_ff, str_left_in;
   logic [1:0]             usage_idx_ff, usage_idx_in;
   logic                   rejected_ff, rejected_in;
   logic                   complete_ff, complete_in;
   logic                   frame_over_ff, frame_over_in;

   // output buffer
   result_type             out_ff, out_in;
   result_type             skid_ff, skid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   skid_valid_ff, skid_valid_in;

   // parse step helpers
   logic                   accept;
   logic [7:0]             b;
   logic [63:0]            acc_merged;
   logic [3:0]             bif_inc;
   logic                   fld_done;
   logic [31:0]            left_dec;
   logic [32:0]            offset33;
   logic [32:0]            frame33;
   logic [32:0]            used33;
   logic [32:0]            avail33;
   logic                   is_end;
   logic [30:0]            msg_done_inc;
   logic [31:0]            parts_done_inc;
   logic [2:0]             usage_next;
   logic                   ok_final;
   result_type             res;

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = out_ff.data;
   assign rsp_tuser  = out_ff.field_kind;
   assign rsp_tlast  = out_ff.frame_end;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff     <= RST_FRAME_LENGTH;
         expected_magic_ff   <= RST_EXPECTED_MAGIC;
         expected_version_ff <= RST_EXPECTED_VERSION;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_LENGTH:     frame_length_ff     <= csr_wdata[31:0];
            CSR_EXPECTED_MAGIC:   expected_magic_ff   <= csr_wdata;
            CSR_EXPECTED_VERSION: expected_version_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // byte lands in the accumulator lane picked by its position in the field
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         acc_merged[8*i +: 8] = (bif_ff[2:0] == 3'(i)) ? (acc_ff[8*i +: 8] | b)
                                                      : acc_ff[8*i +: 8];
      end
   end

   assign bif_inc        = bif_ff + 4'd1;
   assign fld_done       = bif_inc >= field_width(phase_ff);
   assign left_dec       = (str_left_ff != 32'd0) ? str_left_ff - 32'd1 : 32'd0;
   assign offset33       = {{OFF_PAD{1'b0}}, offset_ff};
   assign frame33        = {1'b0, frame_length_ff};
   assign used33         = offset33 + 33'd1;
   assign avail33        = (frame33 > used33) ? frame33 - used33 : 33'd0;
   assign is_end         = (frame_length_ff != 32'd0) && (offset33 == frame33 - 33'd1);
   assign msg_done_inc   = msg_done_ff + 31'd1;
   assign parts_done_inc = parts_done_ff + 32'd1;
   assign usage_next     = {1'b0, usage_idx_ff} + 3'd1;
   assign ok_final       = complete_ff && !rejected_ff;

   // one parse step per accepted byte
   always_comb begin
      phase_in       = phase_ff;
      bif_in         = bif_ff;
      acc_in         = acc_ff;
      offset_in      = offset_ff;
      msg_total_in   = msg_total_ff;
      msg_done_in    = msg_done_ff;
      parts_total_in = parts_total_ff;
      parts_done_in  = parts_done_ff;
      str_left_in    = str_left_ff;
      usage_idx_in   = usage_idx_ff;
      rejected_in    = rejected_ff;
      complete_in    = complete_ff;
      frame_over_in  = frame_over_ff;

      res                    = '0;
      res.data.byte_echo     = b;
      res.field_kind         = phase_ff;

      if (frame_over_ff) begin
         // past the end: label only, no state moves
         res.field_kind   = ok_final ? PH_TRAIL : PH_AFTERERR;
         res.data.verdict = ok_final ? VERDICT_ACCEPTED : VERDICT_REJECTED;
      end else begin
         if (phase_ff == PH_DBYTE || phase_ff == PH_NBYTE || phase_ff == PH_IBYTE) begin
            str_left_in = left_dec;
            if (left_dec == 32'd0) begin
               unique case (phase_ff)
                  PH_DBYTE: phase_in = PH_NFLAG;
                  PH_NBYTE: phase_in = PH_IFLAG;
                  default:  phase_in = PH_ERRMARK;
               endcase
            end
         end else if (phase_ff < PH_TRAIL) begin
            acc_in = acc_merged;
            bif_in = bif_inc;
            if (fld_done) begin
               res.data.field_done  = 1'b1;
               res.data.field_value = acc_merged;
               acc_in = '0;
               bif_in = '0;
               unique case (phase_ff)
                  PH_MAGIC: begin
                     if (acc_merged != expected_magic_ff) begin
                        rejected_in = 1'b1;
                        phase_in    = PH_AFTERERR;
                     end else begin
                        phase_in = PH_VERSION;
                     end
                  end
                  PH_VERSION: begin
                     if (acc_merged != {32'd0, expected_version_ff}) begin
                        rejected_in = 1'b1;
                        phase_in    = PH_AFTERERR;
                     end else begin
                        phase_in = PH_COUNT;
                     end
                  end
                  PH_COUNT: begin
                     // count above half the frame length cannot fit
                     if (acc_merged[31:0] > {1'b0, frame_length_ff[31:1]}) begin
                        rejected_in = 1'b1;
                        phase_in    = PH_AFTERERR;
                     end else begin
                        msg_total_in  = acc_merged[30:0];
                        msg_done_in   = '0;
                        parts_done_in = '0;
                        if (acc_merged[31:0] == 32'd0) begin
                           complete_in = 1'b1;
                           phase_in    = PH_TRAIL;
                        end else begin
                           phase_in = PH_ROLE;
                        end
                     end
                  end
                  PH_ROLE:  phase_in = PH_PCOUNT;
                  PH_PCOUNT: begin
                     parts_total_in = acc_merged[31:0];
                     parts_done_in  = '0;
                     phase_in = (acc_merged[31:0] == 32'd0) ? PH_UFLAG : PH_PTYPE;
                  end
                  PH_PTYPE: phase_in = PH_DLEN;
                  PH_DLEN, PH_NLEN, PH_ILEN: begin
                     // string must fit in what is left of the frame
                     if ({1'b0, acc_merged[31:0]} > avail33) begin
                        rejected_in = 1'b1;
                        phase_in    = PH_AFTERERR;
                     end else if (acc_merged[31:0] == 32'd0) begin
                        unique case (phase_ff)
                           PH_DLEN: phase_in = PH_NFLAG;
                           PH_NLEN: phase_in = PH_IFLAG;
                           default: phase_in = PH_ERRMARK;
                        endcase
                     end else begin
                        str_left_in = acc_merged[31:0];
                        unique case (phase_ff)
                           PH_DLEN: phase_in = PH_DBYTE;
                           PH_NLEN: phase_in = PH_NBYTE;
                           default: phase_in = PH_IBYTE;
                        endcase
                     end
                  end
                  PH_NFLAG: phase_in = (acc_merged[7:0] != 8'd0) ? PH_NLEN : PH_IFLAG;
                  PH_IFLAG: phase_in = (acc_merged[7:0] != 8'd0) ? PH_ILEN : PH_ERRMARK;
                  PH_ERRMARK: begin
                     parts_done_in = parts_done_inc;
                     phase_in = (parts_done_inc == parts_total_ff) ? PH_UFLAG : PH_PTYPE;
                  end
                  PH_UFLAG, PH_TOK0, PH_TOK1, PH_TOK2: begin
                     if (phase_ff == PH_UFLAG && acc_merged[7:0] != 8'd0) begin
                        usage_idx_in = '0;
                        phase_in     = PH_TOK0;
                     end else if (phase_ff != PH_UFLAG && usage_next < 3'd3) begin
                        usage_idx_in = usage_next[1:0];
                        phase_in     = (usage_next == 3'd1) ? PH_TOK1 : PH_TOK2;
                     end else begin
                        // message done: no usage block or last counter
                        if (phase_ff != PH_UFLAG) begin
                           usage_idx_in = '0;
                        end
                        msg_done_in   = msg_done_inc;
                        parts_done_in = '0;
                        if (msg_done_inc == msg_total_ff) begin
                           complete_in = 1'b1;
                           phase_in    = PH_TRAIL;
                        end else begin
                           phase_in = PH_ROLE;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end

         // end of frame: unfinished parse is a truncation
         if (is_end) begin
            res.frame_end = 1'b1;
            frame_over_in = 1'b1;
            if (!complete_in) begin
               rejected_in = 1'b1;
               phase_in    = PH_AFTERERR;
            end
         end

         if (offset_ff != {OFFSET_BITS{1'b1}}) begin
            offset_in = offset_ff + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
         end

         priority if (is_end) begin
            res.data.verdict = (complete_in && !rejected_in) ? VERDICT_ACCEPTED
                                                             : VERDICT_REJECTED;
         end else if (rejected_in) begin
            res.data.verdict = VERDICT_REJECTED;
         end else if (complete_in) begin
            res.data.verdict = VERDICT_ACCEPTED;
         end else begin
            res.data.verdict = VERDICT_PENDING;
         end
      end

      res.data.message_index = msg_done_in;
      res.data.part_index    = parts_done_in;
   end

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_MAGIC;
         bif_ff         <= '0;
         acc_ff         <= '0;
         offset_ff      <= '0;
         msg_total_ff   <= '0;
         msg_done_ff    <= '0;
         parts_total_ff <= '0;
         parts_done_ff  <= '0;
         str_left_ff    <= '0;
         usage_idx_ff   <= '0;
         rejected_ff    <= 1'b0;
         complete_ff    <= 1'b0;
         frame_over_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         bif_ff         <= bif_in;
         acc_ff         <= acc_in;
         offset_ff      <= offset_in;
         msg_total_ff   <= msg_total_in;
         msg_done_ff    <= msg_done_in;
         parts_total_ff <= parts_total_in;
         parts_done_ff  <= parts_done_in;
         str_left_ff    <= str_left_in;
         usage_idx_ff   <= usage_idx_in;
         rejected_ff    <= rejected_in;
         complete_ff    <= complete_in;
         frame_over_ff  <= frame_over_in;
      end
   end

   // output register plus skid entry
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
      if (accept) begin
         if (!rsp_valid_in) begin
            out_in       = res;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // skid entry only fills behind a waiting result
   `RSSV_ASSERT_ALWAYS(a_skid_behind_out, clock, reset, !skid_valid_ff || rsp_valid_ff)
   // the error phase and the rejected flag move together
   `RSSV_ASSERT_ALWAYS(a_err_phase_flag, clock, reset, (phase_ff == PH_AFTERERR) == rejected_ff)
   // a frame is never both complete and rejected
   `RSSV_ASSERT_ALWAYS(a_verdict_excl, clock, reset, !(complete_ff && rejected_ff))
   // message progress never passes the header count
   `RSSV_ASSERT_ALWAYS(a_msg_bound, clock, reset, msg_done_ff <= msg_total_ff)
   // after the end byte the offset stays put
   `RSSV_ASSERT_NEXT(a_offset_frozen, clock, reset, frame_over_ff, $stable(offset_ff))

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
// self-checking bench for record_snapshot_stream_validator: one snapshot frame, byte beats
// holds its own parser of the snapshot format; depends on rssv_pkg and the block's rtl

module tb_top;
   import rssv_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int REPORT_LIMIT = 10;
   localparam logic [63:0] POS_MAX = (64'd1 << DEF_OFFSET_BITS) - 64'd1;

   // ways the single frame of the run is brought to its end
   localparam int CLOSE_ACCEPT     = 0;
   localparam int CLOSE_TRUNCATE   = 1;
   localparam int CLOSE_BAD_LENGTH = 2;

   // every block input has a known value from time zero
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_FRAME_LENGTH;
   logic [63:0]            csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic [7:0]             req_tdata = '0;
   logic                   rsp_tready = 1'b0;

   wire                    csr_ready;
   wire                    req_tready;
   wire                    rsp_tvalid;
   wire [143:0]            rsp_tdata;
   wire [4:0]              rsp_tuser;
   wire                    rsp_tlast;

   // when set, neither side idles
   logic steady = 1'b0;
   int   random_msgs;
   int   mismatches = 0;
   int   stall_cycles = 0;

   // labelled beats still owed by the block, oldest first
   result_type expected_labels[$];

   // register copies
   logic [31:0] frame_len_reg;
   logic [63:0] magic_reg;
   logic [31:0] version_reg;

   // parser copy
   phase_type   cur_phase;
   logic [3:0]  field_fill;
   logic [63:0] field_acc;
   logic [63:0] byte_pos;
   logic [31:0] msg_target;
   logic [31:0] msg_seen;
   logic [31:0] part_target;
   logic [31:0] part_seen;
   logic [31:0] str_remaining;
   logic [1:0]  token_idx;
   logic        saw_reject;
   logic        saw_complete;
   logic        past_end;

   always #10 clock = ~clock;

   record_snapshot_stream_validator DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // ---------------------------------------------------------------- parser copy

   function automatic void reset_parser();
      frame_len_reg = RST_FRAME_LENGTH;
      magic_reg     = RST_EXPECTED_MAGIC;
      version_reg   = RST_EXPECTED_VERSION;
      cur_phase     = PH_MAGIC;
      field_fill    = '0;
      field_acc     = '0;
      byte_pos      = '0;
      msg_target    = '0;
      msg_seen      = '0;
      part_target   = '0;
      part_seen     = '0;
      str_remaining = '0;
      token_idx     = '0;
      saw_reject    = 1'b0;
      saw_complete  = 1'b0;
      past_end      = 1'b0;
   endfunction

   // bytes in a fixed-width field; string byte phases have none
   function automatic int field_bytes(input phase_type ph);
      case (ph)
         PH_MAGIC, PH_TOK0, PH_TOK1, PH_TOK2:           return 8;
         PH_VERSION, PH_COUNT, PH_PCOUNT,
         PH_DLEN, PH_NLEN, PH_ILEN:                     return 4;
         PH_ROLE, PH_PTYPE, PH_NFLAG, PH_IFLAG,
         PH_ERRMARK, PH_UFLAG:                          return 1;
         default:                                       return 0;
      endcase
   endfunction

   function automatic void mark_rejected();
      saw_reject = 1'b1;
      cur_phase  = PH_AFTERERR;
   endfunction

   function automatic void finish_message();
      msg_seen++;
      part_seen = '0;
      if (msg_seen == msg_target) begin
         saw_complete = 1'b1;
         cur_phase    = PH_TRAIL;
      end else begin
         cur_phase = PH_ROLE;
      end
   endfunction

   // a fixed-width field has just been assembled: check it and pick the next phase
   function automatic void close_field(input logic [63:0] v);
      logic [63:0] room;
      case (cur_phase)
         PH_MAGIC:
            if (v != magic_reg) mark_rejected();
            else cur_phase = PH_VERSION;
         PH_VERSION:
            if (v != {32'd0, version_reg}) mark_rejected();
            else cur_phase = PH_COUNT;
         PH_COUNT:
            // no more messages than half the frame length
            if (v > {33'd0, frame_len_reg[31:1]}) begin
               mark_rejected();
            end else begin
               msg_target = v[31:0];
               msg_seen   = '0;
               part_seen  = '0;
               if (msg_target == 0) begin
                  saw_complete = 1'b1;
                  cur_phase    = PH_TRAIL;
               end else begin
                  cur_phase = PH_ROLE;
               end
            end
         PH_ROLE:  cur_phase = PH_PCOUNT;
         PH_PCOUNT: begin
            part_target = v[31:0];
            part_seen   = '0;
            cur_phase   = (part_target == 0) ? PH_UFLAG : PH_PTYPE;
         end
         PH_PTYPE: cur_phase = PH_DLEN;
         PH_DLEN, PH_NLEN, PH_ILEN: begin
            // the string must fit in what is left of the frame
            room = ({32'd0, frame_len_reg} > byte_pos + 64'd1) ?
                   {32'd0, frame_len_reg} - byte_pos - 64'd1 : 64'd0;
            if ({32'd0, v[31:0]} > room) begin
               mark_rejected();
            end else if (v[31:0] == 0) begin
               cur_phase = (cur_phase == PH_ILEN) ? PH_ERRMARK : phase_type'(cur_phase + 5'd2);
            end else begin
               str_remaining = v[31:0];
               cur_phase     = phase_type'(cur_phase + 5'd1);
            end
         end
         PH_NFLAG: cur_phase = (v != 0) ? PH_NLEN : PH_IFLAG;
         PH_IFLAG: cur_phase = (v != 0) ? PH_ILEN : PH_ERRMARK;
         PH_ERRMARK: begin
            part_seen++;
            cur_phase = (part_seen == part_target) ? PH_UFLAG : PH_PTYPE;
         end
         PH_UFLAG:
            if (v != 0) begin
               token_idx = '0;
               cur_phase = PH_TOK0;
            end else begin
               finish_message();
            end
         default: begin
            // one of the three token counters
            token_idx++;
            if (token_idx >= 2'd3) begin
               token_idx = '0;
               finish_message();
            end else begin
               cur_phase = phase_type'(PH_TOK0 + token_idx);
            end
         end
      endcase
   endfunction

   // label one accepted byte and advance the parser copy
   function automatic result_type parse_byte(input logic [7:0] b);
      result_type  r;
      logic [63:0] v;
      logic        ok;
      logic        at_end;
      r = '0;
      at_end = 1'b0;
      r.data.byte_echo = b;
      if (past_end) begin
         // beyond the end byte nothing moves any more
         ok = saw_complete && !saw_reject;
         r.field_kind   = ok ? PH_TRAIL : PH_AFTERERR;
         r.data.verdict = ok ? VERDICT_ACCEPTED : VERDICT_REJECTED;
      end else begin
         r.field_kind = cur_phase;
         if (cur_phase == PH_DBYTE || cur_phase == PH_NBYTE || cur_phase == PH_IBYTE) begin
            if (str_remaining != 0) str_remaining--;
            if (str_remaining == 0)
               cur_phase = (cur_phase == PH_IBYTE) ? PH_ERRMARK : phase_type'(cur_phase + 5'd1);
         end else if (cur_phase < PH_TRAIL) begin
            field_acc  = field_acc | (64'(b) << (8 * field_fill[2:0]));
            field_fill = field_fill + 4'd1;
            if (field_fill >= field_bytes(cur_phase)) begin
               v          = field_acc;
               field_acc  = '0;
               field_fill = '0;
               r.data.field_done  = 1'b1;
               r.data.field_value = v;
               close_field(v);
            end
         end
         // end byte: an unfinished parse is a truncation
         if (frame_len_reg != 0 && byte_pos == {32'd0, frame_len_reg} - 64'd1) begin
            at_end   = 1'b1;
            past_end = 1'b1;
            if (!saw_complete) mark_rejected();
         end
         if (byte_pos < POS_MAX) byte_pos++;
         if (at_end)
            r.data.verdict = (saw_complete && !saw_reject) ? VERDICT_ACCEPTED : VERDICT_REJECTED;
         else if (saw_reject)
            r.data.verdict = VERDICT_REJECTED;
         else
            r.data.verdict = saw_complete ? VERDICT_ACCEPTED : VERDICT_PENDING;
      end
      r.frame_end          = at_end;
      r.data.message_index = msg_seen[30:0];
      r.data.part_index    = part_seen;
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers

   // one byte beat; tvalid is only lowered in the idle loop so that back to
   // back beats never see two assignments in one step
   task automatic send_byte(input logic [7:0] b);
      while (!steady && $urandom_range(0, 99) < 29) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      expected_labels.push_back(parse_byte(b));
   endtask

   task automatic send_bytes(ref logic [7:0] q[$]);
      foreach (q[i]) send_byte(q[i]);
   endtask

   // little-endian field of n bytes
   task automatic push_le(ref logic [7:0] q[$], input logic [63:0] v, input int n);
      for (int i = 0; i < n; i++) q.push_back(v[8*i +: 8]);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FRAME_LENGTH:     frame_len_reg = val[31:0];
         CSR_EXPECTED_MAGIC:   magic_reg     = val;
         CSR_EXPECTED_VERSION: version_reg   = val[31:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending and let every owed beat come back before touching registers
   task automatic wait_idle;
      req_tvalid <= 1'b0;
      while (expected_labels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // well-formed message with random content, mostly small
   task automatic build_random_message(ref logic [7:0] q[$]);
      int parts;
      int len;
      q.push_back(8'($urandom));
      parts = $urandom_range(0, 3);
      push_le(q, parts, 4);
      for (int p = 0; p < parts; p++) begin
         q.push_back(8'($urandom));
         len = $urandom_range(0, 6);
         push_le(q, len, 4);
         repeat (len) q.push_back(8'($urandom));
         // optional name, any nonzero flag counts as present
         if ($urandom_range(0, 1)) begin
            q.push_back(8'($urandom_range(1, 255)));
            len = $urandom_range(0, 4);
            push_le(q, len, 4);
            repeat (len) q.push_back(8'($urandom));
         end else begin
            q.push_back(8'd0);
         end
         // optional id
         if ($urandom_range(0, 1)) begin
            q.push_back(8'($urandom_range(1, 255)));
            len = $urandom_range(0, 4);
            push_le(q, len, 4);
            repeat (len) q.push_back(8'($urandom));
         end else begin
            q.push_back(8'd0);
         end
         q.push_back(8'($urandom));
      end
      // optional usage block of three 64-bit counters
      if ($urandom_range(0, 1)) begin
         q.push_back(8'($urandom_range(1, 255)));
         repeat (3) push_le(q, {$urandom, $urandom}, 8);
      end else begin
         q.push_back(8'd0);
      end
   endtask

   // ---------------------------------------------------------------- tests

   // registers at their extremes or random, then a header that passes all checks
   task automatic test_header;
      logic [7:0]  q[$];
      logic [63:0] magic;
      logic [31:0] version;
      case ($urandom_range(0, 2))
         0:       magic = '0;
         1:       magic = '1;
         default: magic = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 2))
         0:       version = '0;
         1:       version = '1;
         default: version = $urandom;
      endcase
      random_msgs = $urandom_range(27, 33);
      // largest frame: the end is placed later by lowering the length
      write_csr(CSR_FRAME_LENGTH, 64'hFFFF_FFFF);
      write_csr(CSR_EXPECTED_MAGIC, magic);
      write_csr(CSR_EXPECTED_VERSION, {32'd0, version});
      push_le(q, magic, 8);
      push_le(q, version, 4);
      // two directed, the random ones and the closing message
      push_le(q, random_msgs + 3, 4);
      send_bytes(q);
   endtask

   // empty message, then one with both kinds of part and all usage extremes
   task automatic test_directed_messages;
      logic [7:0] q[$];
      q.push_back(8'hFF);
      push_le(q, 0, 4);
      q.push_back(8'd0);
      q.push_back(8'h00);
      push_le(q, 2, 4);
      // bare part: empty data, no name, no id
      q.push_back(8'h00);
      push_le(q, 0, 4);
      q.push_back(8'd0);
      q.push_back(8'd0);
      q.push_back(8'h00);
      // full part: empty name string, one-byte id
      q.push_back(8'hFF);
      push_le(q, 3, 4);
      q.push_back(8'h00);
      q.push_back(8'hFF);
      q.push_back(8'($urandom));
      q.push_back(8'h80);
      push_le(q, 0, 4);
      q.push_back(8'h01);
      push_le(q, 1, 4);
      q.push_back(8'($urandom));
      q.push_back(8'hFF);
      q.push_back(8'h40);
      push_le(q, '0, 8);
      push_le(q, '1, 8);
      push_le(q, {$urandom, $urandom}, 8);
      send_bytes(q);
   endtask

   // bulk of the run, with a stretch where neither side idles
   task automatic test_random_messages;
      logic [7:0] q[$];
      for (int i = 0; i < random_msgs; i++) begin
         steady <= (i >= random_msgs / 3) && (i < random_msgs / 2);
         q.delete();
         build_random_message(q);
         send_bytes(q);
      end
      steady <= 1'b0;
   endtask

   // last message, then the frame end placed on purpose and bytes beyond it
   task automatic test_frame_close;
      logic [7:0]  q[$];
      logic [31:0] bad_len;
      int          mode;
      int          span;
      int          total;
      mode = $urandom_range(CLOSE_ACCEPT, CLOSE_BAD_LENGTH);
      case (mode)
         CLOSE_BAD_LENGTH: begin
            q.push_back(8'($urandom));
            push_le(q, $urandom_range(1, 3), 4);
            q.push_back(8'($urandom));
            span = q.size() + 4 + $urandom_range(1, 30);
            // one byte past what the frame has left, or far past it
            bad_len = $urandom_range(0, 1) ? 32'(span - q.size() - 3) : {1'b1, 31'($urandom)};
            push_le(q, bad_len, 4);
         end
         CLOSE_TRUNCATE: begin
            build_random_message(q);
            span = $urandom_range(1, q.size() - 1);
         end
         default: begin
            build_random_message(q);
            span = q.size() + $urandom_range(0, 6);
         end
      endcase
      wait_idle();
      write_csr(CSR_FRAME_LENGTH, byte_pos + span);
      total = ((span > q.size()) ? span : q.size()) + $urandom_range(3, 10);
      // filler is trailing, after-error or beyond-end bytes depending on the mode
      while (q.size() < total) q.push_back(8'($urandom));
      send_bytes(q);
   endtask

   // once the frame is over new settings must not change any label
   task automatic test_registers_after_end;
      logic [7:0] q[$];
      wait_idle();
      write_csr(CSR_FRAME_LENGTH, 64'd1);
      write_csr(CSR_EXPECTED_MAGIC, {$urandom, $urandom});
      write_csr(CSR_EXPECTED_VERSION, {32'd0, $urandom});
      repeat (6) q.push_back(8'($urandom));
      send_bytes(q);
   endtask

   // ---------------------------------------------------------------- result side

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 29);
   end

   // compare each result beat with the oldest owed label
   always @(posedge clock) begin
      result_type   want;
      rsp_data_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_labels.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected rsp beat: kind %0d last %0b data %h",
                        rsp_tuser, rsp_tlast, rsp_tdata);
         end else begin
            want = expected_labels.pop_front();
            if (want.field_kind !== rsp_tuser || want.frame_end !== rsp_tlast ||
                want.data.byte_echo !== got.byte_echo ||
                want.data.field_done !== got.field_done ||
                want.data.field_value !== got.field_value ||
                want.data.message_index !== got.message_index ||
                want.data.part_index !== got.part_index ||
                want.data.verdict !== got.verdict || want.data.pad !== got.pad) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("mismatch at %0t: kind exp %0d got %0d, last exp %0b got %0b",
                           $realtime, want.field_kind, rsp_tuser, want.frame_end, rsp_tlast);
                  $display("   data exp %h", want.data);
                  $display("   data got %h", got);
               end
            end
         end
      end
   end

   // cycles with no beat on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL record_snapshot_stream_validator");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset_parser();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_header();
      test_directed_messages();
      test_random_messages();
      test_frame_close();
      test_registers_after_end();
      req_tvalid <= 1'b0;
      while (expected_labels.size() != 0) @(posedge clock);
      // keep clocking to catch stray beats
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_labels.size() == 0)
         $display("PASS record_snapshot_stream_validator");
      else
         $display("FAIL record_snapshot_stream_validator");
      $finish;
   end

endmodule
